// ===== hdl/sssp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants
// Opcodes, the distance limit and the controller/datapath command and status
// structures.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned DistBits = 22;
  localparam logic [DistBits-1:0] DistMax = 22'h3FFFFF;
  localparam int unsigned NodeBits = 6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_WAIT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic add_edge;
    logic clear_store;
    logic init_run;
    logic scan_start;
    logic scan_step;
    logic settle;
    logic relax_start;
    logic relax_step;
    logic emit_start;
    logic emit_step;
  } ctl_t;

  // Status back to the controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic relax_done;
    logic emit_done;
    logic src_valid;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/single_source_shortest_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// single_source_shortest_path: Dijkstra engine over a stored edge list
// Add-edge and clear words are taken while idle. A run has an init step,
// then for each settled node a minimum scan and pick plus a relaxation
// pass over the single-port edge memory, then a last scan that finds
// nothing, then one result per active node, one per cycle on out_valid (an
// out-of-range source goes straight from init to the results); the
// receiver cannot stall, so results must be taken when strobed. busy stays
// high for the whole run.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned MAX_EDGES   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [5:0]  in_from_node,
  input  wire logic [5:0]  in_to_node,
  input  wire logic [15:0] in_weight,
  input  wire logic [5:0]  in_source_node,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_node_count,
  output logic             out_valid,
  output logic [5:0]       out_node,
  output logic [21:0]      out_distance,
  output logic             out_reachable,
  output logic             out_overflow,
  output logic             out_last
);

  logic [6:0]      count_r;
  sssp_pkg::ctl_t  ctl;
  sssp_pkg::sts_t  sts;

  // Node count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 7'd64;
    else if (cfg_valid) count_r <= cfg_node_count;
  end

  sssp_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_op, .busy, .ctl, .sts
  );

  sssp_dp #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk, .rst_n, .ctl, .sts, .cfg_count(count_r),
    .in_from_node, .in_to_node, .in_weight, .in_source_node,
    .out_valid, .out_node, .out_distance, .out_reachable, .out_overflow, .out_last
  );

endmodule
`default_nettype wire

// ===== hdl/sssp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_ctrl: run sequencer
// Decodes words and steps the datapath through init, select, relax and emit.
// ----------------------------------------------------------------------------
module sssp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     in_op,
  output logic                busy,
  output sssp_pkg::ctl_t      ctl,
  input  wire sssp_pkg::sts_t sts
);

  sssp_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sssp_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  logic go_run;
  assign go_run = start && (in_op == sssp_pkg::OP_RUN);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sssp_pkg::ST_IDLE:       if (go_run) state_nxt = sssp_pkg::ST_INIT;
      sssp_pkg::ST_INIT:       state_nxt = sts.src_valid ? sssp_pkg::ST_SCAN
                                                         : sssp_pkg::ST_EMIT;
      sssp_pkg::ST_SCAN:       if (sts.scan_done) state_nxt = sssp_pkg::ST_PICK;
      sssp_pkg::ST_PICK:       state_nxt = sts.found ? sssp_pkg::ST_RELAX
                                                     : sssp_pkg::ST_EMIT;
      sssp_pkg::ST_RELAX:      state_nxt = sssp_pkg::ST_RELAX_WAIT;
      sssp_pkg::ST_RELAX_WAIT: if (sts.relax_done) state_nxt = sssp_pkg::ST_SCAN;
      sssp_pkg::ST_EMIT:       if (sts.emit_done) state_nxt = sssp_pkg::ST_IDLE;
      default:                 state_nxt = sssp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      sssp_pkg::ST_IDLE: begin
        busy            = 1'b0;
        ctl.add_edge    = start && (in_op == sssp_pkg::OP_ADD);
        ctl.clear_store = start && (in_op == sssp_pkg::OP_CLEAR);
        ctl.init_run    = go_run;
      end
      sssp_pkg::ST_INIT: begin
        ctl.scan_start = sts.src_valid;
        ctl.emit_start = !sts.src_valid;
      end
      sssp_pkg::ST_SCAN:  ctl.scan_step = 1'b1;
      sssp_pkg::ST_PICK: begin
        ctl.settle     = sts.found;
        ctl.emit_start = !sts.found;
      end
      sssp_pkg::ST_RELAX:      ctl.relax_start = 1'b1;
      sssp_pkg::ST_RELAX_WAIT: begin
        ctl.relax_step = 1'b1;
        ctl.scan_start = sts.relax_done;
      end
      sssp_pkg::ST_EMIT:  ctl.emit_step = 1'b1;
      default: ;
    endcase
  end

  // Assertions
  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sssp_pkg::ST_IDLE) |-> !busy) else $error("idle but busy");
  a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (go_run && !busy) |=> (state_r == sssp_pkg::ST_INIT)) else $error("run lost");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.add_edge, ctl.clear_store, ctl.init_run, ctl.scan_step,
              ctl.relax_step, ctl.emit_step})) else $error("cmd overlap");

endmodule
`default_nettype wire

// ===== hdl/sssp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_dp: edge store, node tables and relaxation datapath
// Edge memory with one read port, node distance memory scanned for the
// minimum, and a sequential relax pass per settled node.
// ----------------------------------------------------------------------------
module sssp_dp #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned MAX_EDGES   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sssp_pkg::ctl_t   ctl,
  output sssp_pkg::sts_t        sts,
  input  wire logic [6:0]       cfg_count,
  input  wire logic [5:0]       in_from_node,
  input  wire logic [5:0]       in_to_node,
  input  wire logic [15:0]      in_weight,
  input  wire logic [5:0]       in_source_node,
  output logic                  out_valid,
  output logic [5:0]            out_node,
  output logic [21:0]           out_distance,
  output logic                  out_reachable,
  output logic                  out_overflow,
  output logic                  out_last
);

  localparam int unsigned NB = $clog2(MAX_NODES);
  localparam int unsigned EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CB = $clog2(MAX_EDGES + 1);
  localparam int unsigned DB = sssp_pkg::DistBits;
  localparam int unsigned NCB = $clog2(MAX_NODES + 1);

  // Edge memory: tail, head, weight
  logic [5:0]             etail_mem [MAX_EDGES];
  logic [5:0]             ehead_mem [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] ecost_mem [MAX_EDGES];
  logic [CB-1:0]          ecount_r;
  logic                   drop_r;

  // Active node count, clamped
  logic [NCB-1:0] n_act;
  always_comb begin
    if (cfg_count == 7'd0) n_act = NCB'(1);
    else if ({25'd0, cfg_count} > MAX_NODES) n_act = NCB'(MAX_NODES);
    else n_act = NCB'(cfg_count);
  end

  // Edge store writes
  always_ff @(posedge clk) begin
    if (ctl.add_edge && ecount_r < CB'(MAX_EDGES)) begin
      etail_mem[ecount_r[EB-1:0]] <= in_from_node;
      ehead_mem[ecount_r[EB-1:0]] <= in_to_node;
      ecost_mem[ecount_r[EB-1:0]] <= WEIGHT_BITS'(in_weight);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= '0;
      drop_r   <= 1'b0;
    end else if (ctl.clear_store) begin
      ecount_r <= '0;
      drop_r   <= 1'b0;
    end else if (ctl.add_edge) begin
      if (ecount_r < CB'(MAX_EDGES)) ecount_r <= ecount_r + CB'(1);
      else drop_r <= 1'b1;
    end
  end

  // Node flags
  logic [MAX_NODES-1:0] reached_r, settled_r;
  logic [DB-1:0]        dist_mem [MAX_NODES];
  logic [5:0]           src_r;
  logic                 src_ok;
  assign src_ok = ({1'b0, src_r} < 7'(n_act));

  // Scan for the minimum: one node a cycle, reading dist_mem
  logic [NCB-1:0] scan_r;
  logic [NB-1:0]  best_r;
  logic           found_r;
  logic [DB-1:0]  best_d_r;
  logic [DB-1:0]  rd_dist_r;
  logic [NB-1:0]  rd_idx_r;
  logic           rd_vld_r;

  // Relax pass
  logic [CB-1:0]  eidx_r;
  logic [DB-1:0]  udist_r;
  logic           e_vld_r;
  logic [5:0]     e_tail_r, e_head_r;
  logic [WEIGHT_BITS-1:0] e_cost_r;
  logic           c_vld_r;
  logic [NB-1:0]  c_head_r;
  logic [DB-1:0]  c_cand_r;
  logic           relax_run_r;

  // Last distance write, forwarded to a compare whose read raced it
  logic           fwd_vld_r;
  logic [NB-1:0]  fwd_addr_r;
  logic [DB-1:0]  fwd_data_r;

  // Emit
  logic [NCB-1:0] emit_r;
  logic           emit_run_r;

  // Distance memory single write port, registered read
  logic           dwr_en;
  logic [NB-1:0]  dwr_addr;
  logic [DB-1:0]  dwr_data;
  logic [NB-1:0]  drd_addr;
  logic [DB-1:0]  drd_q;

  always_ff @(posedge clk) begin
    if (dwr_en) dist_mem[dwr_addr] <= dwr_data;
    drd_q <= dist_mem[drd_addr];
  end

  // Read address: relax head, emit, settled node, or scan
  always_comb begin
    if (e_vld_r) drd_addr = e_head_r[NB-1:0];
    else if (emit_run_r) drd_addr = emit_r[NB-1:0];
    else if (ctl.settle) drd_addr = best_r;
    else drd_addr = scan_r[NB-1:0];
  end

  // Candidate distance, saturating
  logic [DB:0] cand_sum;
  assign cand_sum = {1'b0, udist_r} + (DB+1)'(e_cost_r);

  // Head distance read lands with the candidate stage
  logic [DB-1:0] head_dist;
  assign head_dist = (fwd_vld_r && fwd_addr_r == c_head_r) ? fwd_data_r : drd_q;

  logic c_better;
  assign c_better = !reached_r[c_head_r] || (c_cand_r < head_dist);

  always_comb begin
    dwr_en   = 1'b0;
    dwr_addr = src_r[NB-1:0];
    dwr_data = '0;
    if (ctl.init_run) begin
      dwr_en   = 1'b1;
      dwr_addr = in_source_node[NB-1:0];
    end else if (c_vld_r && c_better) begin
      dwr_en   = 1'b1;
      dwr_addr = c_head_r;
      dwr_data = c_cand_r;
    end
  end

  logic relax_busy;
  assign relax_busy = relax_run_r || e_vld_r || c_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r   <= '0;
      settled_r   <= '0;
      src_r       <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      relax_run_r <= 1'b0;
      e_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      emit_run_r  <= 1'b0;
      emit_r      <= '0;
      out_valid   <= 1'b0;
      eidx_r      <= '0;
    end else begin
      out_valid <= emit_run_r && !ctl.emit_start;
      if (ctl.init_run) begin
        src_r     <= in_source_node;
        settled_r <= '0;
        reached_r <= ({1'b0, in_source_node} < 7'(n_act)) ?
                     (MAX_NODES'(1) << in_source_node[NB-1:0]) : '0;
      end
      // scan
      if (ctl.scan_start) begin
        scan_r   <= '0;
        found_r  <= 1'b0;
        rd_vld_r <= 1'b0;
      end else if (ctl.scan_step) begin
        if (scan_r < n_act) scan_r <= scan_r + NCB'(1);
        rd_vld_r <= (scan_r < n_act);
        rd_idx_r <= scan_r[NB-1:0];
        if (rd_vld_r && reached_r[rd_idx_r] && !settled_r[rd_idx_r] &&
            (!found_r || drd_q < best_d_r)) begin
          found_r  <= 1'b1;
          best_r   <= rd_idx_r;
          best_d_r <= drd_q;
        end
      end
      if (ctl.settle) settled_r[best_r] <= 1'b1;
      // relax
      if (ctl.relax_start) begin
        udist_r     <= best_d_r;
        eidx_r      <= '0;
        relax_run_r <= (ecount_r != '0);
      end else if (relax_run_r) begin
        eidx_r  <= eidx_r + CB'(1);
        if (eidx_r + CB'(1) == ecount_r) relax_run_r <= 1'b0;
      end
      e_vld_r <= relax_run_r;
      if (relax_run_r) begin
        e_tail_r <= etail_mem[eidx_r[EB-1:0]];
        e_head_r <= ehead_mem[eidx_r[EB-1:0]];
        e_cost_r <= ecost_mem[eidx_r[EB-1:0]];
      end
      c_vld_r  <= e_vld_r && (e_tail_r[NB-1:0] == best_r) &&
                  ({1'b0, e_tail_r} < 7'(n_act)) &&
                  ({1'b0, e_head_r} < 7'(n_act));
      c_head_r <= e_head_r[NB-1:0];
      c_cand_r <= cand_sum[DB] ? sssp_pkg::DistMax : cand_sum[DB-1:0];
      if (c_vld_r && c_better) reached_r[c_head_r] <= 1'b1;
      fwd_vld_r  <= c_vld_r && c_better;
      fwd_addr_r <= c_head_r;
      fwd_data_r <= c_cand_r;
      // emit
      if (ctl.emit_start) begin
        emit_r     <= '0;
        emit_run_r <= 1'b1;
      end else if (emit_run_r) begin
        emit_r    <= emit_r + NCB'(1);
        out_node  <= 6'(emit_r);
        out_reachable <= reached_r[emit_r[NB-1:0]];
        out_last  <= (emit_r + NCB'(1) == n_act);
        out_overflow <= drop_r;
        if (emit_r + NCB'(1) == n_act) emit_run_r <= 1'b0;
      end
    end
  end

  // Distance of the emitted node comes from the registered memory read, which lands together with out_node
  always_comb begin
    out_distance = out_reachable ? drd_q : '0;
  end

  assign sts.scan_done  = ctl.scan_step && !rd_vld_r && (scan_r == n_act);
  assign sts.found      = found_r;
  assign sts.relax_done = !relax_busy;
  assign sts.emit_done  = out_valid && out_last;
  assign sts.src_valid  = src_ok;

  // Assertions
  a_no_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.init_run |-> !c_vld_r) else $error("init during relax");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecount_r <= CB'(MAX_EDGES)) else $error("edge count over");
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    emit_run_r |-> !relax_run_r) else $error("emit during relax");

endmodule
`default_nettype wire

// ===== bench/tb_single_source_shortest_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_single_source_shortest_path: self-checking bench for the Dijkstra engine
// Words (add edge, run, clear, unused op) and node_count writes are queued by
// the stimulus block and driven on the falling edge with random gaps. Every
// accepted run is predicted here with a plain minimum-selection search, and
// each strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_path;

  localparam int unsigned EdgeDepth = 1024;
  localparam int unsigned QuietCyc  = 6;

  typedef enum logic [1:0] {
    K_WORD,
    K_CFG,
    K_DRAIN,
    K_CALM
  } pend_kind_t;

  typedef struct {
    pend_kind_t     kind;
    sssp_pkg::op_t  op;
    logic [5:0]     tail;
    logic [5:0]     head;
    logic [15:0]    cost;
    logic [5:0]     src;
    logic [6:0]     count;
  } pend_t;

  typedef struct {
    logic [5:0]  node;
    logic [21:0] dval;
    logic        reach;
    logic        ovf;
    logic        last;
  } dist_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [5:0]  in_from_node;
  logic [5:0]  in_to_node;
  logic [15:0] in_weight;
  logic [5:0]  in_source_node;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_node_count;
  logic        out_valid;
  logic [5:0]  out_node;
  logic [21:0] out_distance;
  logic        out_reachable;
  logic        out_overflow;
  logic        out_last;

  single_source_shortest_path u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_weight      (in_weight),
    .in_source_node (in_source_node),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count),
    .out_valid      (out_valid),
    .out_node       (out_node),
    .out_distance   (out_distance),
    .out_reachable  (out_reachable),
    .out_overflow   (out_overflow),
    .out_last       (out_last)
  );

  // Predictor state
  logic [5:0]  e_tail [EdgeDepth];
  logic [5:0]  e_head [EdgeDepth];
  logic [15:0] e_cost [EdgeDepth];
  int          edge_cnt;
  logic        dropped;
  logic [6:0]  node_cnt_reg;

  pend_t       pend_q[$];
  dist_res_t   dist_q[$];
  int          errs;
  int          gap;
  int          quiet;
  bit          calm;
  bit          took_word;
  bit          took_cfg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shortest distances from src over the current edge list
  task automatic predict_run(input logic [5:0] src);
    int          n;
    int          best;
    int          v;
    longint      cand;
    logic [21:0] node_dist [64];
    bit          rch [64];
    bit          settled [64];
    dist_res_t   r;
    n = (node_cnt_reg == 0) ? 1 : ((node_cnt_reg > 64) ? 64 : int'(node_cnt_reg));
    for (int i = 0; i < 64; i++) begin
      node_dist[i] = '0;
      rch[i] = 1'b0;
      settled[i] = 1'b0;
    end
    if (int'(src) < n) begin
      rch[src] = 1'b1;
      forever begin
        best = n;
        for (int i = 0; i < n; i++)
          if (rch[i] && !settled[i] && (best == n || node_dist[i] < node_dist[best]))
            best = i;
        if (best == n) break;
        settled[best] = 1'b1;
        for (int e = 0; e < edge_cnt; e++) begin
          v = e_head[e];
          if (int'(e_tail[e]) == best && v < n) begin
            cand = longint'(node_dist[best]) + longint'(e_cost[e]);
            if (cand > longint'(sssp_pkg::DistMax)) cand = longint'(sssp_pkg::DistMax);
            if (!rch[v] || cand < longint'(node_dist[v])) begin
              node_dist[v] = cand[21:0];
              rch[v] = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node  = i[5:0];
      r.dval  = rch[i] ? node_dist[i] : '0;
      r.reach = rch[i];
      r.ovf   = dropped;
      r.last  = (i == n - 1);
      dist_q.push_back(r);
    end
  endtask

  // Monitor: accept words, config writes and results at the rising edge
  always @(posedge clk) begin
    dist_res_t x;
    took_word = rst_n && start && !busy;
    took_cfg  = rst_n && cfg_valid && cfg_ready;
    if (took_cfg) node_cnt_reg = cfg_node_count;
    if (took_word) begin
      case (sssp_pkg::op_t'(in_op))
        sssp_pkg::OP_ADD: begin
          if (edge_cnt < EdgeDepth) begin
            e_tail[edge_cnt] = in_from_node;
            e_head[edge_cnt] = in_to_node;
            e_cost[edge_cnt] = in_weight;
            edge_cnt++;
          end else begin
            dropped = 1'b1;
          end
        end
        sssp_pkg::OP_CLEAR: begin
          edge_cnt = 0;
          dropped = 1'b0;
        end
        sssp_pkg::OP_RUN: predict_run(in_source_node);
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      if (dist_q.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("unexpected result: node %0d dist %0d", out_node, out_distance);
      end else begin
        x = dist_q.pop_front();
        if (out_node !== x.node || out_distance !== x.dval || out_reachable !== x.reach ||
            out_overflow !== x.ovf || out_last !== x.last) begin
          errs++;
          if (errs <= 10)
            $display({"mismatch: exp node %0d dist %0d reach %0b ovf %0b last %0b,",
                      " got %0d %0d %0b %0b %0b"},
                     x.node, x.dval, x.reach, x.ovf, x.last,
                     out_node, out_distance, out_reachable, out_overflow, out_last);
        end
      end
    end
    quiet = (rst_n && !busy && !out_valid && !start) ? quiet + 1 : 0;
  end

  // Driver: one word or config write at a time, changed on the falling edge
  always @(negedge clk) begin
    logic nx_start;
    logic nx_cfg;
    pend_t w;
    nx_start = start;
    nx_cfg = cfg_valid;
    if (start && took_word) nx_start = 1'b0;
    if (cfg_valid && took_cfg) nx_cfg = 1'b0;
    if (rst_n && !nx_start && !nx_cfg) begin
      if (gap > 0) begin
        gap--;
      end else if (pend_q.size() > 0) begin
        w = pend_q[0];
        case (w.kind)
          K_WORD: begin
            in_op <= w.op;
            in_from_node <= w.tail;
            in_to_node <= w.head;
            in_weight <= w.cost;
            in_source_node <= w.src;
            nx_start = 1'b1;
            void'(pend_q.pop_front());
            if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
          end
          K_CFG: begin
            if (dist_q.size() == 0 && quiet >= QuietCyc) begin
              cfg_node_count <= w.count;
              nx_cfg = 1'b1;
              void'(pend_q.pop_front());
            end
          end
          K_DRAIN: if (dist_q.size() == 0) void'(pend_q.pop_front());
          default: begin
            calm = 1'b1;
            void'(pend_q.pop_front());
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_valid <= nx_cfg;
  end

  task automatic push_word(input sssp_pkg::op_t op, input logic [5:0] tail,
                           input logic [5:0] head, input logic [15:0] cost,
                           input logic [5:0] src);
    pend_t w;
    w.kind = K_WORD;
    w.op = op;
    w.tail = tail;
    w.head = head;
    w.cost = cost;
    w.src = src;
    w.count = '0;
    pend_q.push_back(w);
  endtask

  task automatic push_cfg(input logic [6:0] count);
    pend_t w;
    w = '{K_CFG, sssp_pkg::OP_NONE, '0, '0, '0, '0, count};
    pend_q.push_back(w);
  endtask

  task automatic push_mark(input pend_kind_t kind);
    pend_t w;
    w = '{kind, sssp_pkg::OP_NONE, '0, '0, '0, '0, '0};
    pend_q.push_back(w);
  endtask

  // Node index biased toward the active range, sometimes anywhere
  function automatic logic [5:0] pick_node(input int n);
    if ($urandom_range(0, 5) == 0) return 6'($urandom);
    return 6'($urandom_range(0, (n + 1 > 63) ? 63 : n + 1));
  endfunction

  // Stimulus
  initial begin
    int n;
    int k;
    logic [6:0] cnt;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_node_count = '0;
    in_op = sssp_pkg::OP_NONE;
    in_from_node = '0;
    in_to_node = '0;
    in_weight = '0;
    in_source_node = '0;
    edge_cnt = 0;
    dropped = 1'b0;
    node_cnt_reg = 7'd64;
    errs = 0;
    gap = 0;
    quiet = 0;
    calm = 1'b0;
    took_word = 1'b0;
    took_cfg = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero-weight ties, unused op, counts out of range
    push_word(sssp_pkg::OP_ADD, 6'd0, 6'd63, 16'hFFFF, '0);
    push_word(sssp_pkg::OP_ADD, 6'd63, 6'd0, 16'h0000, '0);
    push_word(sssp_pkg::OP_ADD, 6'd5, 6'd6, 16'h0000, '0);
    push_word(sssp_pkg::OP_ADD, 6'd5, 6'd7, 16'h0000, '0);
    push_word(sssp_pkg::OP_ADD, 6'd6, 6'd8, 16'd3, '0);
    push_word(sssp_pkg::OP_ADD, 6'd7, 6'd8, 16'd1, '0);
    push_word(sssp_pkg::OP_ADD, 6'd63, 6'd5, 16'hAAAA, '0);
    push_word(sssp_pkg::OP_NONE, 6'h3F, 6'h3F, 16'hFFFF, 6'h3F);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd0);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd63);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd5);
    push_cfg(7'd1);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd0);
    push_cfg(7'd0);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd0);
    push_cfg(7'd127);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd63);
    push_cfg(7'd10);
    push_word(sssp_pkg::OP_ADD, 6'd3, 6'd20, 16'd1, '0);
    push_word(sssp_pkg::OP_ADD, 6'd20, 6'd4, 16'd1, '0);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd40);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd3);
    push_word(sssp_pkg::OP_CLEAR, '0, '0, '0, '0);
    push_word(sssp_pkg::OP_RUN, '0, '0, '0, 6'd9);

    // Random phases: clear, load a few edges, run; some noise
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 4))
        0: cnt = 7'd1;
        1: cnt = 7'd64;
        2: cnt = 7'($urandom_range(2, 6));
        3: cnt = 7'($urandom);
        default: cnt = 7'($urandom_range(8, 40));
      endcase
      push_cfg(cnt);
      n = (cnt == 0) ? 1 : ((cnt > 64) ? 64 : int'(cnt));
      if (p == 1) push_mark(K_DRAIN);
      if (p == 3) push_mark(K_CALM);
      for (int s = 0; s < 4; s++) begin
        if ($urandom_range(0, 1) == 0) push_word(sssp_pkg::OP_CLEAR, '0, '0, '0, '0);
        k = $urandom_range(0, 8);
        for (int j = 0; j < k; j++)
          push_word(sssp_pkg::OP_ADD, pick_node(n), pick_node(n),
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)),
                    6'($urandom));
        if ($urandom_range(0, 5) == 0)
          push_word(sssp_pkg::OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom),
                    6'($urandom));
        push_word(sssp_pkg::OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom),
                  pick_node(n));
      end
    end

    wait (pend_q.size() == 0 && !start && !cfg_valid && dist_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errs == 0 && dist_q.size() == 0) begin
      $display("tb_single_source_shortest_path OK");
    end else begin
      $display("tb_single_source_shortest_path NOT OK");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40000000;
    $display("tb_single_source_shortest_path NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/sssp_pkg.sv
hdl/sssp_ctrl.sv
hdl/sssp_dp.sv
hdl/single_source_shortest_path.sv
bench/tb_single_source_shortest_path.sv
